// File: sv/assert_macros.svh
// assertion macros used by the scheduler rtl file
// no dependencies; the including module supplies clk_i and rst_ni
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, off while in reset
`define PQS_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, off while in reset
`define PQS_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: sv/pqs_pkg.sv
// types and codes of the priority queue scheduler
// no dependencies; used by the top level
package pqs_pkg;

  // one queue entry: priority high, id, remaining time low
  typedef struct packed {
    logic [7:0]  prio;
    logic [7:0]  id;
    logic [15:0] rem;
  } pqs_entry_t;

  localparam int unsigned EntryWidth = $bits(pqs_entry_t);

  // input word kind
  typedef enum logic {
    OP_ADMIT = 1'b0,
    OP_TICK  = 1'b1
  } pqs_op_e;

  // result status codes
  typedef enum logic [1:0] {
    ST_RAN   = 2'd0,
    ST_IDLE  = 2'd1,
    ST_ADMIT = 2'd2,
    ST_FULL  = 2'd3
  } pqs_status_e;

  // sequencer states, one-hot
  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_HEAD  = 5'b00010,
    S_WALK  = 5'b00100,
    S_PLACE = 5'b01000,
    S_RESP  = 5'b10000
  } pqs_state_e;

  // configuration register indexes
  localparam logic REG_LIMIT = 1'b0;

  localparam logic [7:0] LimitReset = 8'd10;

endpackage

// File: sv/pqs_ram.sv
// queue storage: one write port, one read port with registered read data
// no dependencies
module pqs_ram #(
  parameter int unsigned Depth = 16,
  parameter int unsigned AddrW = 4,
  parameter int unsigned DataW = 32
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [DataW-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [DataW-1:0] rdata_o
);

  logic [DataW-1:0] mem_q [Depth];
  logic [DataW-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: sv/priority_queue_scheduler.sv
// Priority queue scheduler. Tasks sit in a ring buffer in priority order (lower value first,
// first-in among equals). An admit word walks backward from the tail, one entry per cycle,
// moving each entry with a higher priority value one place on, then writes the new task into
// the gap; an admit to a full queue is answered with a full status. A tick word on an
// empty queue is answered idle; otherwise it reads the head from the registered-read
// memory, runs it if its priority is within run_priority_limit, pops it and, unless done,
// reinserts it by the same walk. A result still waiting at the output register holds the
// sequencer in its response state until that register frees.
// One word is worked at a time; the next is taken while the previous result waits at the
// output register. No clearing pass is needed after reset.
`include "assert_macros.svh"

module priority_queue_scheduler #(
  parameter int unsigned QUEUE_DEPTH = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // input stream
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [31:0] s_axis_tdata_i,  // task_id[7:0], task_priority[15:8], run_time[31:16]
  input  logic [0:0]  s_axis_tuser_i,  // operation[0]
  // result stream
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [55:0] m_axis_tdata_o,  // ran_id[7:0], ran_priority[15:8], time_now[47:16],
                                       // task_done[48], zero[55:49]
  output logic [1:0]  m_axis_tuser_o,  // status[1:0]
  // configuration
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int unsigned PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned CW = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned SW = PW + 2;

  // ring position of a logical queue place
  function automatic logic [PW-1:0] slot(input logic [PW-1:0] base, input logic [CW-1:0] ofs);
    logic [SW-1:0] sum;
    sum = SW'(base) + SW'(ofs);
    if (sum >= SW'(QUEUE_DEPTH)) begin
      sum = sum - SW'(QUEUE_DEPTH);
    end
    return sum[PW-1:0];
  endfunction

  pqs_pkg::pqs_state_e  state_q, state_d;
  logic [CW-1:0]        count_q, count_d;
  logic [PW-1:0]        head_q, head_d;
  logic [CW-1:0]        k_q, k_d;
  pqs_pkg::pqs_entry_t  ins_q, ins_d;
  logic [31:0]          tick_q, tick_d;
  logic [7:0]           limit_q;
  pqs_pkg::pqs_status_e res_status_q, res_status_d;
  logic [7:0]           res_id_q, res_id_d;
  logic [7:0]           res_prio_q, res_prio_d;
  logic                 res_done_q, res_done_d;
  logic [31:0]          now_q, now_d;
  logic                 out_valid_q, out_valid_d;
  logic [55:0]          out_data_q, out_data_d;
  logic [1:0]           out_user_q, out_user_d;

  logic                        ram_we;
  logic [PW-1:0]               ram_waddr;
  pqs_pkg::pqs_entry_t         ram_wdata;
  logic                        ram_re;
  logic [PW-1:0]               ram_raddr;
  logic [pqs_pkg::EntryWidth-1:0] ram_rdata;
  pqs_pkg::pqs_entry_t         rd_entry;
  logic [15:0]                 rem_dec;
  logic                        in_fire;
  logic                        cfg_wr;
  logic                        chk_cnt_ok;
  logic                        chk_walk_ok;
  logic                        chk_full_adm;
  logic                        chk_tick_in;
  logic                        in_resp;

  assign rd_entry = pqs_pkg::pqs_entry_t'(ram_rdata);
  assign rem_dec  = (rd_entry.rem != 16'd0) ? (rd_entry.rem - 16'd1) : 16'd0;

  pqs_ram #(
    .Depth(QUEUE_DEPTH),
    .AddrW(PW),
    .DataW(pqs_pkg::EntryWidth)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .re_i   (ram_re),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  // configuration port
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready && (paddr[2] == pqs_pkg::REG_LIMIT);
  assign prdata = (paddr[2] == pqs_pkg::REG_LIMIT) ? {24'd0, limit_q} : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q <= pqs_pkg::LimitReset;
    end else if (cfg_wr) begin
      limit_q <= pwdata[7:0];
    end
  end

  // handshakes
  assign s_axis_tready_o = (state_q == pqs_pkg::S_IDLE);
  assign in_fire         = s_axis_tvalid_i && s_axis_tready_o;
  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_data_q;
  assign m_axis_tuser_o  = out_user_q;

  // sequencer
  always_comb begin
    state_d      = state_q;
    count_d      = count_q;
    head_d       = head_q;
    k_d          = k_q;
    ins_d        = ins_q;
    tick_d       = tick_q;
    res_status_d = res_status_q;
    res_id_d     = res_id_q;
    res_prio_d   = res_prio_q;
    res_done_d   = res_done_q;
    now_d        = now_q;
    out_valid_d  = out_valid_q && !m_axis_tready_i;
    out_data_d   = out_data_q;
    out_user_d   = out_user_q;
    ram_we       = 1'b0;
    ram_waddr    = slot(head_q, k_q);
    ram_wdata    = ins_q;
    ram_re       = 1'b0;
    ram_raddr    = head_q;

    case (state_q)
      pqs_pkg::S_IDLE: begin
        if (in_fire) begin
          now_d      = tick_q;
          res_id_d   = 8'd0;
          res_prio_d = 8'd0;
          res_done_d = 1'b0;
          if (s_axis_tuser_i[0] == pqs_pkg::OP_TICK) begin
            tick_d = tick_q + 32'd1;
            if (count_q == '0) begin
              res_status_d = pqs_pkg::ST_IDLE;
              state_d      = pqs_pkg::S_RESP;
            end else begin
              ram_re    = 1'b1;
              ram_raddr = head_q;
              state_d   = pqs_pkg::S_HEAD;
            end
          end else if (count_q == CW'(QUEUE_DEPTH)) begin
            res_status_d = pqs_pkg::ST_FULL;
            state_d      = pqs_pkg::S_RESP;
          end else begin
            ins_d.prio   = s_axis_tdata_i[15:8];
            ins_d.id     = s_axis_tdata_i[7:0];
            ins_d.rem    = s_axis_tdata_i[31:16];
            k_d          = count_q;
            res_status_d = pqs_pkg::ST_ADMIT;
            if (count_q == '0) begin
              state_d = pqs_pkg::S_PLACE;
            end else begin
              ram_re    = 1'b1;
              ram_raddr = slot(head_q, count_q - CW'(1));
              state_d   = pqs_pkg::S_WALK;
            end
          end
        end
      end
      pqs_pkg::S_HEAD: begin
        if (rd_entry.prio > limit_q) begin
          res_status_d = pqs_pkg::ST_IDLE;
          state_d      = pqs_pkg::S_RESP;
        end else begin
          res_status_d = pqs_pkg::ST_RAN;
          res_id_d     = rd_entry.id;
          res_prio_d   = rd_entry.prio;
          head_d       = slot(head_q, CW'(1));
          count_d      = count_q - CW'(1);
          if (rem_dec == 16'd0) begin
            res_done_d = 1'b1;
            state_d    = pqs_pkg::S_RESP;
          end else begin
            // reinsert behind its equals, walking from the new tail
            ins_d.prio = rd_entry.prio;
            ins_d.id   = rd_entry.id;
            ins_d.rem  = rem_dec;
            k_d        = count_q - CW'(1);
            if (count_q == CW'(1)) begin
              state_d = pqs_pkg::S_PLACE;
            end else begin
              ram_re    = 1'b1;
              ram_raddr = slot(head_q, count_q - CW'(1));
              state_d   = pqs_pkg::S_WALK;
            end
          end
        end
      end
      pqs_pkg::S_WALK: begin
        // read data holds logical place k-1
        ram_we = 1'b1;
        if (rd_entry.prio > ins_q.prio) begin
          ram_wdata = rd_entry;
          k_d       = k_q - CW'(1);
          if (k_q == CW'(1)) begin
            state_d = pqs_pkg::S_PLACE;
          end else begin
            ram_re    = 1'b1;
            ram_raddr = slot(head_q, k_q - CW'(2));
          end
        end else begin
          ram_wdata = ins_q;
          count_d   = count_q + CW'(1);
          state_d   = pqs_pkg::S_RESP;
        end
      end
      pqs_pkg::S_PLACE: begin
        ram_we    = 1'b1;
        ram_wdata = ins_q;
        count_d   = count_q + CW'(1);
        state_d   = pqs_pkg::S_RESP;
      end
      pqs_pkg::S_RESP: begin
        if (!out_valid_q || m_axis_tready_i) begin
          out_valid_d = 1'b1;
          out_data_d  = {7'd0, res_done_q, now_q, res_prio_q, res_id_q};
          out_user_d  = res_status_q;
          state_d     = pqs_pkg::S_IDLE;
        end
      end
      default: begin
        state_d = pqs_pkg::S_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= pqs_pkg::S_IDLE;
      count_q     <= '0;
      head_q      <= '0;
      k_q         <= '0;
      tick_q      <= 32'd0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      head_q      <= head_d;
      k_q         <= k_d;
      tick_q      <= tick_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    ins_q        <= ins_d;
    res_status_q <= res_status_d;
    res_id_q     <= res_id_d;
    res_prio_q   <= res_prio_d;
    res_done_q   <= res_done_d;
    now_q        <= now_d;
    out_data_q   <= out_data_d;
    out_user_q   <= out_user_d;
  end

  // check terms
  assign chk_cnt_ok   = (count_q <= CW'(QUEUE_DEPTH));
  assign chk_walk_ok  = (k_q != '0) && (k_q <= count_q);
  assign chk_full_adm = in_fire && (s_axis_tuser_i[0] == pqs_pkg::OP_ADMIT)
                        && (count_q == CW'(QUEUE_DEPTH));
  assign chk_tick_in  = in_fire && (s_axis_tuser_i[0] == pqs_pkg::OP_TICK);
  assign in_resp      = (state_q == pqs_pkg::S_RESP);

  // checks
  `PQS_ASSERT_IMP(a_count_bound, state_q == pqs_pkg::S_IDLE, chk_cnt_ok, "queue count above depth")
  `PQS_ASSERT_IMP(a_walk_range, state_q == pqs_pkg::S_WALK, chk_walk_ok, "walk place out of range")
  `PQS_ASSERT_NXT(a_full_hold, chk_full_adm, in_resp && (count_q == $past(count_q)), "full admit")
  `PQS_ASSERT_NXT(a_tick_step, chk_tick_in, tick_q == $past(tick_q) + 32'd1, "tick not counted")

endmodule
